// ----- rtl/core/frt_pkg.sv -----
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants for the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

  // fixed field widths
  localparam int LEN_W   = 16;
  localparam int KIND_W  = 2;
  localparam int SEQ_W   = 8;
  localparam int IDX_W   = 8;
  localparam int TIME_W  = 32;
  localparam int STAT_W  = 3;
  localparam int TOTAL_W = 21;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;

  // one context per sequence id
  localparam int CONTEXTS = 256;

  // fragment kinds
  localparam logic [KIND_W-1:0] KIND_WHOLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MID   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LAST  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_TOO_SHORT = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STAT_W-1:0] ST_STORED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_WHOLE     = 3'd4;
  localparam logic [STAT_W-1:0] ST_COMPLETE  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PERIOD = 4'd1;

  // register reset values
  localparam logic [TIME_W-1:0] TIMEOUT_RST      = 32'd10000;
  localparam logic [TIME_W-1:0] SWEEP_PERIOD_RST = 32'd1000;

  // input fragment descriptor
  typedef struct packed {
    logic [LEN_W-1:0]  item_length;
    logic [KIND_W-1:0] frag_kind;
    logic [SEQ_W-1:0]  sequence_req;
    logic [IDX_W-1:0]  piece_index;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  // result descriptor
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SEQ_W-1:0]   sequence_out;
    logic [LEN_W-1:0]   payload_length;
    logic [TOTAL_W-1:0] reassembled_length;
  } out_item_t;

  // age compare flags
  typedef struct packed {
    logic gt;
    logic lt;
  } age_cmp_t;

endpackage

// ----- rtl/core/fragment_reassembly_tracker.sv -----
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Per-sequence fragment bitmap tracking with timed expiry of stale contexts.
// ----------------------------------------------------------------------------
// One fragment descriptor is handled at a time by a small sequencer around a
// single shared age compare unit and a 256-entry context memory (one read
// port with registered data, one write port). After acceptance a too-short
// item goes from the check state to finish; a whole packet or a bad index
// goes through dispatch, any other fragment through dispatch, lookup and
// update. For an item that is not too short, once the sweep period has elapsed
// the expiry sweep adds one read and one check per context. in_stall is high
// from acceptance until the result is loaded into the output register, which
// happens once the previous result has been taken. Contexts carry a valid flag
// in flip-flops cleared by reset, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker #(
  parameter int MAX_PIECES   = 32,
  parameter int HEADER_BYTES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // fragment input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  frt_pkg::in_item_t              in_item,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output frt_pkg::out_item_t             out_item,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PW = $clog2(MAX_PIECES);

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CHECK     = 3'd1;
  localparam logic [2:0] S_SWEEP_RD  = 3'd2;
  localparam logic [2:0] S_SWEEP_CHK = 3'd3;
  localparam logic [2:0] S_DISPATCH  = 3'd4;
  localparam logic [2:0] S_LOOKUP    = 3'd5;
  localparam logic [2:0] S_UPDATE    = 3'd6;
  localparam logic [2:0] S_FINISH    = 3'd7;

  typedef struct packed {
    logic [MAX_PIECES-1:0]       rmap;
    logic                        last_seen;
    logic [PW-1:0]               last_piece;
    logic [frt_pkg::TOTAL_W-1:0] total;
    logic [frt_pkg::TIME_W-1:0]  start;
  } ctx_t;

  logic [2:0] state_r, state_nxt;
  frt_pkg::in_item_t item_r;
  logic [frt_pkg::TIME_W-1:0] timeout_r, period_r, last_sweep_r;
  logic [frt_pkg::SEQ_W-1:0] cnt_r;
  logic restart_r;
  logic [frt_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [frt_pkg::TOTAL_W-1:0] res_total_r, res_total_nxt;
  logic out_valid_r;
  frt_pkg::out_item_t out_item_r;

  // context memory and valid flags
  ctx_t ctx_mem [frt_pkg::CONTEXTS];
  logic [frt_pkg::CONTEXTS-1:0] ctx_vld_r;
  logic [frt_pkg::SEQ_W-1:0] rd_addr;
  ctx_t rd_q;
  logic rd_vld_q;
  logic wr_en;
  ctx_t wr_data;

  ctx_t raw, cur, upd;
  logic [MAX_PIECES-1:0] piece_bit, full_mask;
  logic short_item, is_dup, is_done;
  logic [frt_pkg::LEN_W-1:0] payload;
  logic [frt_pkg::TIME_W-1:0] cmp_ref, cmp_lim;
  frt_pkg::age_cmp_t cmp;

  // shared age compare
  assign cmp_ref = (state_r == S_CHECK) ? last_sweep_r : raw.start;
  assign cmp_lim = (state_r == S_CHECK) ? period_r : timeout_r;

  frt_age_cmp u_age_cmp (
    .now_ms   (item_r.now_ms),
    .ref_ms   (cmp_ref),
    .limit_ms (cmp_lim),
    .flags    (cmp)
  );

  // item decode
  assign short_item = item_r.item_length < frt_pkg::LEN_W'(HEADER_BYTES);
  assign payload    = short_item ? '0 : item_r.item_length - frt_pkg::LEN_W'(HEADER_BYTES);
  assign piece_bit  = MAX_PIECES'(1) << item_r.piece_index[PW-1:0];

  // memory read data, invalid entries read as cleared
  assign raw = rd_vld_q ? rd_q : '0;
  assign cur = restart_r ? '0 : raw;

  // context update
  always_comb begin
    upd = cur;
    if (cur.rmap == '0 && cur.start == '0) begin
      upd.start = item_r.now_ms;
    end
    upd.rmap  = cur.rmap | piece_bit;
    upd.total = cur.total + frt_pkg::TOTAL_W'(payload);
    if (item_r.frag_kind == frt_pkg::KIND_LAST) begin
      upd.last_seen  = 1'b1;
      upd.last_piece = item_r.piece_index[PW-1:0];
    end
  end

  // expected bitmap for the last index
  always_comb begin
    for (int i = 0; i < MAX_PIECES; i++) begin
      full_mask[i] = i <= int'(upd.last_piece);
    end
  end

  assign is_dup  = (cur.rmap & piece_bit) != '0;
  assign is_done = upd.last_seen && (upd.rmap == full_mask);

  assign rd_addr = (state_r == S_SWEEP_RD) ? cnt_r : item_r.sequence_req;
  assign wr_en   = (state_r == S_UPDATE) && !is_dup && !is_done;
  assign wr_data = upd;

  // memory read and write ports
  always_ff @(posedge clk) begin
    rd_q     <= ctx_mem[rd_addr];
    rd_vld_q <= ctx_vld_r[rd_addr];
    if (wr_en) begin
      ctx_mem[item_r.sequence_req] <= wr_data;
    end
  end

  // valid flags: set on store, cleared on expiry, completion or reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_vld_r <= '0;
    end else if (state_r == S_SWEEP_CHK) begin
      if (raw.rmap != '0 && raw.start != '0 && cmp.gt) begin
        ctx_vld_r[cnt_r] <= 1'b0;
      end
    end else if (state_r == S_UPDATE && !is_dup) begin
      ctx_vld_r[item_r.sequence_req] <= !is_done;
    end
  end

  // sequencer next state and result
  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_total_nxt  = res_total_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (short_item) begin
          res_status_nxt = frt_pkg::ST_TOO_SHORT;
          res_total_nxt  = '0;
          state_nxt      = S_FINISH;
        end else if (cmp.gt) begin
          state_nxt = S_SWEEP_RD;
        end else begin
          state_nxt = S_DISPATCH;
        end
      end
      S_SWEEP_RD: begin
        state_nxt = S_SWEEP_CHK;
      end
      S_SWEEP_CHK: begin
        state_nxt = (cnt_r == '1) ? S_DISPATCH : S_SWEEP_RD;
      end
      S_DISPATCH: begin
        if (item_r.frag_kind == frt_pkg::KIND_WHOLE) begin
          res_status_nxt = frt_pkg::ST_WHOLE;
          res_total_nxt  = frt_pkg::TOTAL_W'(payload);
          state_nxt      = S_FINISH;
        end else if (item_r.piece_index >= frt_pkg::IDX_W'(MAX_PIECES)) begin
          res_status_nxt = frt_pkg::ST_BAD_INDEX;
          res_total_nxt  = '0;
          state_nxt      = S_FINISH;
        end else begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (is_dup) begin
          res_status_nxt = frt_pkg::ST_DUPLICATE;
          res_total_nxt  = '0;
        end else if (is_done) begin
          res_status_nxt = frt_pkg::ST_COMPLETE;
          res_total_nxt  = upd.total;
        end else begin
          res_status_nxt = frt_pkg::ST_STORED;
          res_total_nxt  = '0;
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_sweep_r <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      timeout_r    <= frt_pkg::TIMEOUT_RST;
      period_r     <= frt_pkg::SWEEP_PERIOD_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CHECK && !short_item && cmp.gt) begin
        last_sweep_r <= item_r.now_ms;
        cnt_r        <= '0;
      end else if (state_r == S_SWEEP_CHK) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == S_FINISH && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // configuration transaction
      if (cfg_valid) begin
        if (cfg_index == frt_pkg::REG_TIMEOUT) begin
          timeout_r <= cfg_data;
        end else if (cfg_index == frt_pkg::REG_SWEEP_PERIOD) begin
          period_r <= cfg_data;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_item;
    end
    if (state_r == S_LOOKUP) begin
      restart_r <= (item_r.piece_index == '0) && raw.rmap != '0 &&
                   raw.start != '0 && cmp.lt;
    end
    res_status_r <= res_status_nxt;
    res_total_r  <= res_total_nxt;
    if (state_r == S_FINISH && (!out_valid_r || !out_stall)) begin
      out_item_r.status             <= res_status_r;
      out_item_r.sequence_out       <= item_r.sequence_req;
      out_item_r.payload_length     <= payload;
      out_item_r.reassembled_length <= res_total_r;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

endmodule

// ----- rtl/core/frt_age_cmp.sv -----
// ----------------------------------------------------------------------------
// frt_age_cmp
// Shared age unit: elapsed time modulo 2^32 compared against a limit.
// ----------------------------------------------------------------------------
module frt_age_cmp (
  input  logic [frt_pkg::TIME_W-1:0] now_ms,
  input  logic [frt_pkg::TIME_W-1:0] ref_ms,
  input  logic [frt_pkg::TIME_W-1:0] limit_ms,
  output frt_pkg::age_cmp_t          flags
);

  logic [frt_pkg::TIME_W-1:0] age;

  // wrapping difference then magnitude compare
  assign age      = now_ms - ref_ms;
  assign flags.gt = age > limit_ms;
  assign flags.lt = age < limit_ms;

endmodule

// ----- tb/sv/fragment_reassembly_tracker_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_checker
// Watches the fragment, result and register channels of the tracker. Keeps
// its own copy of the per-sequence context table and predicts one result per
// accepted fragment. Compares every result transaction, field by field, with
// the oldest prediction.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_checker #(
  parameter int MAX_PIECES   = 32,
  parameter int HEADER_BYTES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  frt_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  frt_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [frt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             pending_count,
  output int                             error_count
);

  // predicted context table, one entry per sequence id
  logic [31:0]                 piece_map  [frt_pkg::CONTEXTS];
  logic                        tail_seen  [frt_pkg::CONTEXTS];
  logic [4:0]                  tail_index [frt_pkg::CONTEXTS];
  logic [frt_pkg::TOTAL_W-1:0] byte_sum   [frt_pkg::CONTEXTS];
  logic [frt_pkg::TIME_W-1:0]  ctx_start  [frt_pkg::CONTEXTS];
  logic [frt_pkg::TIME_W-1:0]  prev_sweep_ms;

  // predicted register contents
  logic [frt_pkg::TIME_W-1:0]  age_limit_ms;
  logic [frt_pkg::TIME_W-1:0]  sweep_gap_ms;

  frt_pkg::out_item_t expected_results [$];
  frt_pkg::out_item_t want;
  int errors  = 0;
  int backlog = 0;

  assign error_count   = errors;
  assign pending_count = backlog;

  // one line per mismatch
  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp);
    if (got !== exp) begin
      flag_error($sformatf("sequence %0d %s got %0h expected %0h",
                           want.sequence_out, name, got, exp));
    end
  endtask

  function automatic void drop_context(input int k);
    piece_map[k]  = '0;
    tail_seen[k]  = 1'b0;
    tail_index[k] = '0;
    byte_sum[k]   = '0;
    ctx_start[k]  = '0;
  endfunction

  // expected result of one fragment, updating the context table
  function automatic frt_pkg::out_item_t track_fragment(input frt_pkg::in_item_t frag);
    frt_pkg::out_item_t         res;
    logic [frt_pkg::TIME_W-1:0] age;
    logic [31:0]                bit_sel;
    logic [31:0]                want_map;
    logic [frt_pkg::LEN_W-1:0]  payload;
    int                         s;
    res              = '0;
    s                = frag.sequence_req;
    res.sequence_out = frag.sequence_req;
    if (frag.item_length < HEADER_BYTES) begin
      res.status = frt_pkg::ST_TOO_SHORT;
    end else begin
      payload            = frag.item_length - frt_pkg::LEN_W'(HEADER_BYTES);
      res.payload_length = payload;
      // expiry sweep over all contexts once the period has passed
      age = frag.now_ms - prev_sweep_ms;
      if (age > sweep_gap_ms) begin
        for (int k = 0; k < frt_pkg::CONTEXTS; k++) begin
          age = frag.now_ms - ctx_start[k];
          if (piece_map[k] != 0 && ctx_start[k] != 0 && age > age_limit_ms) begin
            drop_context(k);
          end
        end
        prev_sweep_ms = frag.now_ms;
      end
      if (frag.frag_kind == frt_pkg::KIND_WHOLE) begin
        res.status             = frt_pkg::ST_WHOLE;
        res.reassembled_length = frt_pkg::TOTAL_W'(payload);
      end else if (frag.piece_index >= MAX_PIECES) begin
        res.status = frt_pkg::ST_BAD_INDEX;
      end else begin
        bit_sel = 32'd1 << frag.piece_index[4:0];
        // piece 0 on a young live context starts the packet over
        age = frag.now_ms - ctx_start[s];
        if (frag.piece_index == 0 && piece_map[s] != 0 && ctx_start[s] != 0 &&
            age < age_limit_ms) begin
          drop_context(s);
        end
        if (piece_map[s] == 0 && ctx_start[s] == 0) begin
          ctx_start[s] = frag.now_ms;
        end
        if ((piece_map[s] & bit_sel) != 0) begin
          res.status = frt_pkg::ST_DUPLICATE;
        end else begin
          piece_map[s] = piece_map[s] | bit_sel;
          byte_sum[s]  = byte_sum[s] + frt_pkg::TOTAL_W'(payload);
          if (frag.frag_kind == frt_pkg::KIND_LAST) begin
            tail_seen[s]  = 1'b1;
            tail_index[s] = frag.piece_index[4:0];
          end
          if (tail_index[s] == 5'd31) begin
            want_map = 32'hFFFF_FFFF;
          end else begin
            want_map = (32'd1 << ({27'd0, tail_index[s]} + 32'd1)) - 32'd1;
          end
          if (tail_seen[s] && piece_map[s] == want_map) begin
            res.status             = frt_pkg::ST_COMPLETE;
            res.reassembled_length = byte_sum[s];
            drop_context(s);
          end else begin
            res.status = frt_pkg::ST_STORED;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < frt_pkg::CONTEXTS; k++) begin
        drop_context(k);
      end
      prev_sweep_ms = '0;
      age_limit_ms  = frt_pkg::TIMEOUT_RST;
      sweep_gap_ms  = frt_pkg::SWEEP_PERIOD_RST;
      expected_results.delete();
      backlog <= 0;
    end else begin
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result for sequence %0d with nothing expected",
                               out_item.sequence_out));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(out_item.status), 32'(want.status));
          check_field("sequence_out", 32'(out_item.sequence_out),
                      32'(want.sequence_out));
          check_field("payload_length", 32'(out_item.payload_length),
                      32'(want.payload_length));
          check_field("reassembled_length", 32'(out_item.reassembled_length),
                      32'(want.reassembled_length));
        end
      end
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          frt_pkg::REG_TIMEOUT:      age_limit_ms = cfg_data;
          frt_pkg::REG_SWEEP_PERIOD: sweep_gap_ms = cfg_data;
          default: ;
        endcase
      end
      // fragment transaction
      if (in_valid && !in_stall) begin
        expected_results.push_back(track_fragment(in_item));
      end
      backlog <= expected_results.size();
    end
  end

endmodule

// ----- tb/sv/fragment_reassembly_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_tb
// Drives fragment descriptors and register writes into the tracker and takes
// its results under random idling on both channels. A short directed list
// covers the corner cases, then interleaved packets with random content and
// some noise run under several timeout and sweep settings. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_tb;

  localparam int PIECES      = 32;
  localparam int HDR         = 4;
  localparam int ACTIVE      = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 600;
  localparam int LIMIT       = 4000000;

  // spare kind code, handled as a fragment that is not last
  localparam logic [frt_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  frt_pkg::in_item_t              in_item   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  frt_pkg::out_item_t             out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [frt_pkg::CFG_IDX_W-1:0]  cfg_index = frt_pkg::REG_TIMEOUT;
  logic [frt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int pending;
  int errors;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_reqs    = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int cycle_count  = 0;

  logic [frt_pkg::TIME_W-1:0] clk_ms   = '0;
  logic [frt_pkg::TIME_W-1:0] jump_max = '0;
  logic [frt_pkg::TIME_W-1:0] tmo_val;

  // open packets being sent interleaved
  logic [frt_pkg::SEQ_W-1:0] pkt_seq   [ACTIVE];
  int unsigned               pkt_len   [ACTIVE];
  int unsigned               pkt_pos   [ACTIVE];
  logic [4:0]                pkt_order [ACTIVE][32];

  fragment_reassembly_tracker #(
    .MAX_PIECES   (PIECES),
    .HEADER_BYTES (HDR)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fragment_reassembly_tracker_checker #(
    .MAX_PIECES   (PIECES),
    .HEADER_BYTES (HDR)
  ) tracker_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_count (pending),
    .error_count   (errors)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // one fragment transaction, valid dropped after the accepting edge
  task automatic send_frag(input logic [frt_pkg::LEN_W-1:0] len,
                           input logic [frt_pkg::KIND_W-1:0] kind,
                           input logic [frt_pkg::SEQ_W-1:0] seq,
                           input logic [frt_pkg::IDX_W-1:0] idx,
                           input logic [frt_pkg::TIME_W-1:0] now);
    frt_pkg::in_item_t frag;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    frag.item_length  = len;
    frag.frag_kind    = kind;
    frag.sequence_req = seq;
    frag.piece_index  = idx;
    frag.now_ms       = now;
    in_valid <= 1'b1;
    in_item  <= frag;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic put_reg(input logic [frt_pkg::CFG_IDX_W-1:0] idx,
                         input logic [frt_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic [frt_pkg::TIME_W-1:0] tmo,
                          input logic [frt_pkg::TIME_W-1:0] period);
    put_reg(frt_pkg::REG_TIMEOUT, tmo);
    put_reg(frt_pkg::REG_SWEEP_PERIOD, period);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [frt_pkg::LEN_W-1:0] frag_len();
    if ($urandom_range(0, 9) == 0) begin
      frag_len = frt_pkg::LEN_W'($urandom_range(HDR, 40));
    end else begin
      frag_len = frt_pkg::LEN_W'($urandom_range(HDR, 65535));
    end
  endfunction

  // new packet in a slot: piece 0 first, the rest shuffled
  task automatic open_packet(input int slot);
    int unsigned n;
    int unsigned k;
    int unsigned sel;
    logic [4:0]  tmp;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      n = 32;
    end else if (sel < 30) begin
      n = $urandom_range(9, 31);
    end else begin
      n = $urandom_range(1, 8);
    end
    if ($urandom_range(0, 3) == 0) begin
      pkt_seq[slot] = frt_pkg::SEQ_W'($urandom_range(0, 3));
    end else begin
      pkt_seq[slot] = frt_pkg::SEQ_W'($urandom_range(0, 255));
    end
    pkt_len[slot] = n;
    pkt_pos[slot] = 0;
    for (int j = 0; j < n; j++) begin
      pkt_order[slot][j] = j[4:0];
    end
    for (int j = n - 1; j > 1; j--) begin
      k                  = $urandom_range(1, j);
      tmp                = pkt_order[slot][j];
      pkt_order[slot][j] = pkt_order[slot][k];
      pkt_order[slot][k] = tmp;
    end
  endtask

  // interleaved packets with random content, plus noise and broken packets
  task automatic random_traffic(input int count);
    int          slot;
    int unsigned pick;
    logic [4:0]  piece;
    logic [1:0]  kind;
    repeat (count) begin
      if ($urandom_range(0, 99) < 3) begin
        clk_ms = clk_ms + $urandom_range(0, jump_max);
      end else begin
        clk_ms = clk_ms + $urandom_range(0, 3);
      end
      slot = $urandom_range(0, ACTIVE - 1);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // next piece of an open packet
        piece = pkt_order[slot][pkt_pos[slot]];
        if (piece == pkt_len[slot] - 1) begin
          kind = frt_pkg::KIND_LAST;
        end else if ($urandom_range(0, 9) == 0) begin
          kind = KIND_SPARE;
        end else begin
          kind = frt_pkg::KIND_MID;
        end
        send_frag(frag_len(), kind, pkt_seq[slot], {3'd0, piece}, clk_ms);
        pkt_pos[slot]++;
        if (pkt_pos[slot] == pkt_len[slot]) begin
          open_packet(slot);
        end
      end else if (pick < 83) begin
        // packet given up half way, its context left to expire
        open_packet(slot);
        send_frag(frag_len(), frt_pkg::KIND_WHOLE, pkt_seq[slot],
                  frt_pkg::IDX_W'($urandom_range(0, 255)), clk_ms);
      end else if (pick < 87) begin
        send_frag(frag_len(), frt_pkg::KIND_WHOLE, frt_pkg::SEQ_W'($urandom_range(0, 255)),
                  frt_pkg::IDX_W'($urandom_range(0, 255)), clk_ms);
      end else if (pick < 91) begin
        // too short, any other content
        send_frag(frt_pkg::LEN_W'($urandom_range(0, HDR - 1)),
                  frt_pkg::KIND_W'($urandom_range(0, 3)),
                  frt_pkg::SEQ_W'($urandom_range(0, 255)),
                  frt_pkg::IDX_W'($urandom_range(0, 255)), clk_ms);
      end else if (pick < 95) begin
        send_frag(frag_len(), frt_pkg::KIND_W'($urandom_range(1, 3)), pkt_seq[slot],
                  frt_pkg::IDX_W'($urandom_range(PIECES, 255)), clk_ms);
      end else if (pick < 98) begin
        // repeat of a piece already sent, or piece 0 when none has been sent yet
        if (pkt_pos[slot] > 0) begin
          piece = pkt_order[slot][$urandom_range(0, pkt_pos[slot] - 1)];
        end else begin
          piece = '0;
        end
        send_frag(frag_len(), frt_pkg::KIND_MID, pkt_seq[slot], {3'd0, piece}, clk_ms);
      end else begin
        // stray piece, possibly past the last index
        send_frag(frag_len(), frt_pkg::KIND_W'($urandom_range(1, 3)), pkt_seq[slot],
                  frt_pkg::IDX_W'($urandom_range(0, 31)), clk_ms);
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle_pct = 26;
    rcv_idle_pct <= 82;
    for (int s = 0; s < ACTIVE; s++) begin
      open_packet(s);
    end

    // directed, register defaults
    send_frag(16'd0, frt_pkg::KIND_WHOLE, 8'd0, 8'd0, 32'd0);
    send_frag(16'd3, frt_pkg::KIND_LAST, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send_frag(16'd4, frt_pkg::KIND_WHOLE, 8'd7, 8'd0, 32'd5);
    send_frag(16'hFFFF, frt_pkg::KIND_WHOLE, 8'd255, 8'd31, 32'd10);
    send_frag(16'd100, frt_pkg::KIND_MID, 8'd9, 8'd32, 32'd20);
    send_frag(16'd100, frt_pkg::KIND_LAST, 8'd9, 8'd255, 32'd30);
    // context started at time zero keeps a zero start, then a duplicate
    send_frag(16'd10, frt_pkg::KIND_MID, 8'd1, 8'd0, 32'd0);
    send_frag(16'd10, frt_pkg::KIND_MID, 8'd1, 8'd0, 32'd0);
    send_frag(16'd20, frt_pkg::KIND_LAST, 8'd1, 8'd1, 32'd40);
    // last piece out of order, spare kind in the middle
    send_frag(16'd60, frt_pkg::KIND_MID, 8'd3, 8'd0, 32'd100);
    send_frag(16'd50, frt_pkg::KIND_LAST, 8'd3, 8'd2, 32'd110);
    send_frag(16'd70, KIND_SPARE, 8'd3, 8'd1, 32'd120);
    // piece 0 again restarts a young context
    send_frag(16'd30, frt_pkg::KIND_MID, 8'd4, 8'd0, 32'd200);
    send_frag(16'd30, frt_pkg::KIND_MID, 8'd4, 8'd1, 32'd210);
    send_frag(16'd40, frt_pkg::KIND_MID, 8'd4, 8'd0, 32'd220);
    send_frag(16'd44, frt_pkg::KIND_LAST, 8'd4, 8'd1, 32'd230);
    // piece past the last index, cleared later by the sweep
    send_frag(16'd30, frt_pkg::KIND_MID, 8'd5, 8'd0, 32'd300);
    send_frag(16'd30, frt_pkg::KIND_MID, 8'd5, 8'd3, 32'd310);
    send_frag(16'd30, frt_pkg::KIND_LAST, 8'd5, 8'd1, 32'd320);
    send_frag(16'd20, frt_pkg::KIND_WHOLE, 8'd6, 8'd0, 32'd20000);
    send_frag(16'd30, frt_pkg::KIND_LAST, 8'd5, 8'd0, 32'd20010);
    // sweep with the time about to wrap
    send_frag(16'd20, frt_pkg::KIND_WHOLE, 8'd0, 8'd0, 32'hFFFF_FFF0);
    clk_ms = 32'hFFFF_FFF0;
    drain();

    // lowest settings: sweep period and timeout of 1, so contexts expire soon
    set_regs(32'd1, 32'd1);
    jump_max = 32'd8;
    random_traffic(40);
    drain();

    // highest settings: no sweep, full range time jumps, long receiver hold-off
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    jump_max = 32'hFFFF_FFFF;
    random_traffic(60);
    hold_reqs <= hold_reqs + 1;
    random_traffic(190);
    drain();

    // mid settings, sender idles more than the receiver
    snd_idle_pct = 82;
    rcv_idle_pct <= 26;
    tmo_val = $urandom_range(50, 500);
    set_regs(tmo_val, $urandom_range(20, 200));
    jump_max = tmo_val << 1;
    random_traffic(300);
    drain();

    // no idling on either side
    snd_idle_pct = 0;
    rcv_idle_pct <= 0;
    tmo_val = $urandom_range(50, 500);
    set_regs(tmo_val, $urandom_range(20, 200));
    jump_max = tmo_val << 1;
    random_traffic(300);
    drain();

    tmo_val = $urandom_range(1000, 5000);
    set_regs(tmo_val, $urandom_range(500, 2000));
    jump_max = tmo_val << 1;
    random_traffic(100);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/frt_pkg.sv
rtl/core/frt_age_cmp.sv
rtl/core/fragment_reassembly_tracker.sv
tb/sv/fragment_reassembly_tracker_checker.sv
tb/sv/fragment_reassembly_tracker_tb.sv
